### src/cscr_pkg.sv
`default_nettype none
package cscr_pkg;

  localparam int SqrtSteps = 32;
  localparam int DivSteps  = 15;

  localparam logic [15:0] BounceReset = 16'd4096;
  localparam logic [15:0] SkinReset   = 16'd256;
  localparam logic [14:0] UnitQ14     = 15'd16384;

  localparam logic REG_BOUNCE = 1'b0;
  localparam logic REG_SKIN   = 1'b1;

  // per-item context carried through the root and divide pipelines
  typedef struct packed {
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] bvx;
    logic signed [31:0] bvy;
    logic signed [32:0] rvx;
    logic signed [32:0] rvy;
    logic signed [25:0] dx;
    logic signed [25:0] dy;
    logic [24:0]        s;
    logic               contact;
    logic               zero;
  } ctx_t;

  typedef struct packed {
    logic en;
    logic valid;
  } pipe_ctl_t;

  // round(x / 2^s), halves away from zero
  function automatic logic signed [63:0] rshr(input logic signed [63:0] x, input int s);
    logic [63:0] m;
    logic [63:0] r;
    m = x[63] ? (64'd0 - x) : x;
    r = (m + (64'd1 << (s - 1))) >> s;
    return x[63] ? $signed(64'd0 - r) : $signed(r);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

endpackage
`default_nettype wire

### src/circle_static_contact_resolve.sv
// Channel   Dir  Beat contents
// s_axis    in   tdata: body, obstacle positions, velocities, radii (304 bits)
// m_axis    out  tdata: new position, velocity, normal, closing speed; tuser: collided
// apb       in   bounce_gain at 0x0, skin_gap at 0x4
//
// One beat enters per cycle while the pipe advances; each beat runs through stages A
// and B, the 32-step square root, the 15-step normal divide, P1-P7, output register.
// All stages advance together whenever the output register is empty or taken.
// A stall freezes every stage; valid bits travel with the data, so nothing drops.
// rst is synchronous, clears valid bits and sets bounce_gain to 1.0, skin_gap to 256.
`default_nettype none
module circle_static_contact_resolve import cscr_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // body_x, body_y, body_vx, body_vy, body_radius, obstacle_x, obstacle_y,
  // obs_radius, obstacle_vx, obstacle_vy
  input  wire logic [303:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // new_x, new_y, new_vx, new_vy, normal_x, normal_y, close_rate
  output logic [191:0]      m_tdata,
  // collided
  output logic              m_tuser,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  logic [15:0] bounce_gain, skin_gap;
  logic        en;

  cscr_csr u_csr (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .bounce_gain, .skin_gap
  );

  // advance the whole pipe unless the output beat is stuck
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // ---- stage A: differences
  logic signed [31:0] in_bx, in_by, in_bvx, in_bvy, in_ox, in_oy, in_ovx, in_ovy;
  logic [23:0]        in_rb, in_ro;
  assign in_bx  = s_tdata[31:0];
  assign in_by  = s_tdata[63:32];
  assign in_bvx = s_tdata[95:64];
  assign in_bvy = s_tdata[127:96];
  assign in_rb  = s_tdata[151:128];
  assign in_ox  = s_tdata[183:152];
  assign in_oy  = s_tdata[215:184];
  assign in_ro  = s_tdata[239:216];
  assign in_ovx = s_tdata[271:240];
  assign in_ovy = s_tdata[303:272];

  logic               va;
  logic signed [31:0] a_bx, a_by, a_bvx, a_bvy;
  logic signed [32:0] a_dx, a_dy, a_rvx, a_rvy;
  logic [24:0]        a_s;

  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else if (en) va <= s_tvalid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      a_bx  <= in_bx;
      a_by  <= in_by;
      a_bvx <= in_bvx;
      a_bvy <= in_bvy;
      a_dx  <= 33'(in_bx) - 33'(in_ox);
      a_dy  <= 33'(in_by) - 33'(in_oy);
      a_rvx <= 33'(in_bvx) - 33'(in_ovx);
      a_rvy <= 33'(in_bvy) - 33'(in_ovy);
      a_s   <= 25'(in_rb) + 25'(in_ro);
    end
  end

  // ---- stage B: box test and squares
  logic [32:0] a_mx, a_my;
  logic        a_near;
  assign a_mx   = a_dx[32] ? 33'd0 - a_dx : a_dx;
  assign a_my   = a_dy[32] ? 33'd0 - a_dy : a_dy;
  assign a_near = (a_mx < 33'(a_s)) && (a_my < 33'(a_s));

  logic        vb, b_near;
  logic [49:0] b_sqx, b_sqy, b_ss;
  ctx_t        b_ctx;

  always_ff @(posedge clk) begin
    if (rst) vb <= 1'b0;
    else if (en) vb <= va;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      b_near <= a_near;
      b_sqx  <= 50'(a_mx[24:0]) * 50'(a_mx[24:0]);
      b_sqy  <= 50'(a_my[24:0]) * 50'(a_my[24:0]);
      b_ss   <= 50'(a_s) * 50'(a_s);
      b_ctx  <= '{bx: a_bx, by: a_by, bvx: a_bvx, bvy: a_bvy, rvx: a_rvx, rvy: a_rvy,
                  dx: a_dx[25:0], dy: a_dy[25:0], s: a_s, contact: 1'b0, zero: 1'b0};
    end
  end

  // ---- circle test feeds the root pipe
  logic [50:0] b_q;
  ctx_t        b_ctx2;
  assign b_q = 51'(b_sqx) + 51'(b_sqy);
  always_comb begin
    b_ctx2         = b_ctx;
    b_ctx2.contact = b_near && (b_q < 51'(b_ss));
    b_ctx2.zero    = b_q == 51'd0;
  end

  logic        vs;
  logic [31:0] dist14;
  ctx_t        s_ctx;

  cscr_sqrt u_sqrt (
    .clk, .rst,
    .ctl      (pipe_ctl_t'{en: en, valid: vb}),
    .rad      ({1'b0, b_q, 12'd0}),
    .in_ctx   (b_ctx2),
    .out_valid(vs),
    .root     (dist14),
    .out_ctx  (s_ctx)
  );

  logic [25:0] s_mx, s_my;
  assign s_mx = s_ctx.dx[25] ? 26'd0 - s_ctx.dx : s_ctx.dx;
  assign s_my = s_ctx.dy[25] ? 26'd0 - s_ctx.dy : s_ctx.dy;

  logic        vd;
  logic [14:0] qx, qy;
  logic [31:0] d_dist;
  ctx_t        d_ctx;

  cscr_div u_div (
    .clk, .rst,
    .ctl      (pipe_ctl_t'{en: en, valid: vs}),
    .span     (s_ctx.zero ? 32'd1 : dist14),
    .mag_x    (s_mx[24:0]),
    .mag_y    (s_my[24:0]),
    .in_ctx   (s_ctx),
    .out_valid(vd),
    .quo_x    (qx),
    .quo_y    (qy),
    .out_dist (d_dist),
    .out_ctx  (d_ctx)
  );

  // ---- P1: signed normal and push depth
  logic [14:0] cx, cy;
  assign cx = (qx > UnitQ14) ? UnitQ14 : qx;
  assign cy = (qy > UnitQ14) ? UnitQ14 : qy;

  logic               v1;
  logic signed [15:0] n1x, n1y;
  logic signed [33:0] p1_push;
  ctx_t               c1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= vd;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      c1 <= d_ctx;
      if (d_ctx.zero) begin
        n1x <= 16'(UnitQ14);
        n1y <= 16'sd0;
        p1_push <= $signed({3'b0, d_ctx.s, 6'd0}) + $signed({12'd0, skin_gap, 6'd0});
      end else begin
        n1x <= d_ctx.dx[25] ? -$signed({1'b0, cx}) : $signed({1'b0, cx});
        n1y <= d_ctx.dy[25] ? -$signed({1'b0, cy}) : $signed({1'b0, cy});
        p1_push <= $signed({3'b0, d_ctx.s, 6'd0}) - $signed({2'b0, d_dist})
                 + $signed({12'd0, skin_gap, 6'd0});
      end
    end
  end

  // ---- P2: products for push-out and approach speed
  logic               v2;
  logic signed [15:0] n2x, n2y;
  logic signed [49:0] p2x, p2y, a2x, a2y;
  ctx_t               c2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      c2  <= c1;
      n2x <= n1x;
      n2y <= n1y;
      p2x <= 50'(n1x) * 50'(p1_push);
      p2y <= 50'(n1y) * 50'(p1_push);
      a2x <= 50'(c1.rvx) * 50'(n1x);
      a2y <= 50'(c1.rvy) * 50'(n1y);
    end
  end

  // ---- P3: new position, dot product
  logic               v3;
  logic signed [15:0] n3x, n3y;
  logic signed [31:0] x3, y3;
  logic signed [50:0] a3;
  ctx_t               c3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      c3  <= c2;
      n3x <= n2x;
      n3y <= n2y;
      x3  <= sat32(64'(c2.bx) + rshr(64'(p2x), 20));
      y3  <= sat32(64'(c2.by) + rshr(64'(p2y), 20));
      a3  <= 51'(a2x) + 51'(a2y);
    end
  end

  // ---- P4: round approach speed
  logic signed [63:0] a3r;
  assign a3r = rshr(64'(a3), 14);

  logic               v4, neg4;
  logic signed [15:0] n4x, n4y;
  logic signed [31:0] x4, y4, cl4;
  logic signed [36:0] a8;
  ctx_t               c4;
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      c4   <= c3;
      n4x  <= n3x;
      n4y  <= n3y;
      x4   <= x3;
      y4   <= y3;
      a8   <= a3r[36:0];
      cl4  <= sat32(64'sd0 - a3r);
      neg4 <= a3[50];
    end
  end

  // ---- P5: scale by bounce
  logic               v5, neg5;
  logic signed [15:0] n5x, n5y;
  logic signed [31:0] x5, y5, cl5;
  logic signed [53:0] bp5;
  ctx_t               c5;
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= v4;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      c5   <= c4;
      n5x  <= n4x;
      n5y  <= n4y;
      x5   <= x4;
      y5   <= y4;
      cl5  <= cl4;
      neg5 <= neg4;
      bp5  <= 54'(a8) * 54'($signed({1'b0, bounce_gain}));
    end
  end

  // ---- P6: round impulse
  logic signed [63:0] imp_r;
  assign imp_r = rshr(64'(bp5), 12);

  logic               v6, neg6;
  logic signed [15:0] n6x, n6y;
  logic signed [31:0] x6, y6, cl6;
  logic signed [41:0] imp6;
  ctx_t               c6;
  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (en) v6 <= v5;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      c6   <= c5;
      n6x  <= n5x;
      n6y  <= n5y;
      x6   <= x5;
      y6   <= y5;
      cl6  <= cl5;
      neg6 <= neg5;
      imp6 <= imp_r[41:0];
    end
  end

  // ---- P7: impulse along normal
  logic               v7, neg7;
  logic signed [15:0] n7x, n7y;
  logic signed [31:0] x7, y7, cl7;
  logic signed [57:0] vp7x, vp7y;
  ctx_t               c7;
  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else if (en) v7 <= v6;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      c7   <= c6;
      n7x  <= n6x;
      n7y  <= n6y;
      x7   <= x6;
      y7   <= y6;
      cl7  <= cl6;
      neg7 <= neg6;
      vp7x <= 58'(imp6) * 58'(n6x);
      vp7y <= 58'(imp6) * 58'(n6y);
    end
  end

  // ---- output register
  logic signed [31:0] vx7, vy7;
  assign vx7 = sat32(64'(c7.bvx) - rshr(64'(vp7x), 14));
  assign vy7 = sat32(64'(c7.bvy) - rshr(64'(vp7y), 14));

  logic signed [31:0] o_x, o_y, o_vx, o_vy, o_cl;
  logic signed [15:0] o_nx, o_ny;
  logic               o_col;

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (en) m_tvalid <= v7;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      o_col <= c7.contact;
      if (c7.contact) begin
        o_x  <= x7;
        o_y  <= y7;
        o_vx <= neg7 ? vx7 : c7.bvx;
        o_vy <= neg7 ? vy7 : c7.bvy;
        o_nx <= n7x;
        o_ny <= n7y;
        o_cl <= cl7;
      end else begin
        // pass the body through untouched
        o_x  <= c7.bx;
        o_y  <= c7.by;
        o_vx <= c7.bvx;
        o_vy <= c7.bvy;
        o_nx <= 16'sd0;
        o_ny <= 16'sd0;
        o_cl <= 32'sd0;
      end
    end
  end

  assign m_tdata = {o_cl, o_ny, o_nx, o_vy, o_vx, o_y, o_x};
  assign m_tuser = o_col;

`ifndef SYNTHESIS
  a_ready_tracks_out: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("ready does not follow output register state");

  a_no_contact_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> (o_nx == 16'sd0 && o_ny == 16'sd0 && o_cl == 32'sd0))
    else $error("normal or closing speed nonzero without contact");

  a_normal_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (o_nx <= 16'sd16384 && o_nx >= -16'sd16384
                             && o_ny <= 16'sd16384 && o_ny >= -16'sd16384))
    else $error("normal component out of unit range");

  a_no_contact_pass: assert property (@(posedge clk) disable iff (rst)
    en && v7 && !c7.contact |=> (o_x == $past(c7.bx) && o_vy == $past(c7.bvy)))
    else $error("body altered without contact");
`endif

endmodule
`default_nettype wire

### src/cscr_csr.sv
`default_nettype none
module cscr_csr import cscr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [15:0]      bounce_gain,
  output logic [15:0]      skin_gap
);
  logic wr;
  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      bounce_gain <= BounceReset;
      skin_gap    <= SkinReset;
    end else if (wr) begin
      if (paddr[2] == REG_BOUNCE) bounce_gain <= pwdata[15:0];
      else skin_gap <= pwdata[15:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_BOUNCE) prdata = {16'd0, bounce_gain};
    else prdata = {16'd0, skin_gap};
  end
endmodule
`default_nettype wire

### src/cscr_sqrt.sv
`default_nettype none
module cscr_sqrt import cscr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire pipe_ctl_t   ctl,
  input  wire logic [63:0] rad,
  input  wire ctx_t        in_ctx,
  output logic             out_valid,
  output logic [31:0]      root,
  output ctx_t             out_ctx
);
  logic [63:0] rem  [0:SqrtSteps];
  logic [63:0] acc  [0:SqrtSteps];
  logic        vld  [0:SqrtSteps];
  ctx_t        ctx  [0:SqrtSteps];

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else if (ctl.en) vld[0] <= ctl.valid;
  end
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      rem[0] <= rad;
      acc[0] <= 64'd0;
      ctx[0] <= in_ctx;
    end
  end

  // one result bit per stage
  for (genvar k = 0; k < SqrtSteps; k++) begin : g_step
    localparam logic [63:0] Bit = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;
    logic        ge;
    assign trial = acc[k] + Bit;
    assign ge    = rem[k] >= trial;
    always_ff @(posedge clk) begin
      if (rst) vld[k+1] <= 1'b0;
      else if (ctl.en) vld[k+1] <= vld[k];
    end
    always_ff @(posedge clk) begin
      if (ctl.en) begin
        rem[k+1] <= ge ? rem[k] - trial : rem[k];
        acc[k+1] <= ge ? (acc[k] >> 1) + Bit : acc[k] >> 1;
        ctx[k+1] <= ctx[k];
      end
    end
  end

  assign out_valid = vld[SqrtSteps];
  assign root      = acc[SqrtSteps][31:0];
  assign out_ctx   = ctx[SqrtSteps];
endmodule
`default_nettype wire

### src/cscr_div.sv
`default_nettype none
module cscr_div import cscr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire pipe_ctl_t   ctl,
  input  wire logic [31:0] span,
  input  wire logic [24:0] mag_x,
  input  wire logic [24:0] mag_y,
  input  wire ctx_t        in_ctx,
  output logic             out_valid,
  output logic [14:0]      quo_x,
  output logic [14:0]      quo_y,
  output logic [31:0]      out_dist,
  output ctx_t             out_ctx
);
  logic [46:0] rx  [0:DivSteps];
  logic [46:0] ry  [0:DivSteps];
  logic [14:0] qx  [0:DivSteps];
  logic [14:0] qy  [0:DivSteps];
  logic [31:0] dv  [0:DivSteps];
  logic        vld [0:DivSteps];
  ctx_t        ctx [0:DivSteps];

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else if (ctl.en) vld[0] <= ctl.valid;
  end
  // numerator carries the half-divisor rounding term
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      rx[0]  <= {2'b0, mag_x, 20'd0} + {16'd0, span[31:1]};
      ry[0]  <= {2'b0, mag_y, 20'd0} + {16'd0, span[31:1]};
      qx[0]  <= '0;
      qy[0]  <= '0;
      dv[0]  <= span;
      ctx[0] <= in_ctx;
    end
  end

  for (genvar k = 0; k < DivSteps; k++) begin : g_step
    logic [46:0] dsh;
    logic        gx, gy;
    assign dsh = {15'd0, dv[k]} << (DivSteps - 1 - k);
    assign gx  = rx[k] >= dsh;
    assign gy  = ry[k] >= dsh;
    always_ff @(posedge clk) begin
      if (rst) vld[k+1] <= 1'b0;
      else if (ctl.en) vld[k+1] <= vld[k];
    end
    always_ff @(posedge clk) begin
      if (ctl.en) begin
        rx[k+1]  <= gx ? rx[k] - dsh : rx[k];
        ry[k+1]  <= gy ? ry[k] - dsh : ry[k];
        qx[k+1]  <= {qx[k][13:0], gx};
        qy[k+1]  <= {qy[k][13:0], gy};
        dv[k+1]  <= dv[k];
        ctx[k+1] <= ctx[k];
      end
    end
  end

  assign out_valid = vld[DivSteps];
  assign quo_x     = qx[DivSteps];
  assign quo_y     = qy[DivSteps];
  assign out_dist  = dv[DivSteps];
  assign out_ctx   = ctx[DivSteps];
endmodule
`default_nettype wire
